// ===== hw/rtl/hmp_pkg.sv =====
package hmp_pkg;

    // Sequencer states: message bytes, 0x80 mark, block flush, zero fill, length field
    typedef enum logic [2:0]
    {
        ST_MSG,
        ST_MARK,
        ST_FLUSH,
        ST_FILL,
        ST_LEN
    } hmp_state_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_BLOCK_SIZE  = 2'd0;
    localparam logic [1:0] CFG_LENGTH_SIZE = 2'd1;
    localparam logic [1:0] CFG_LENGTH_BE   = 2'd2;

    // Padding constants
    localparam logic [7:0] PAD_MARK         = 8'h80;
    localparam logic [7:0] PAD_ZERO         = 8'h00;
    localparam logic [7:0] BLOCK_BYTES_64   = 8'd64;
    localparam logic [7:0] BLOCK_BYTES_128  = 8'd128;
    localparam logic [7:0] LEN_BYTES_8      = 8'd8;
    localparam logic [7:0] LEN_BYTES_16     = 8'd16;

    // Controls handed to the length serialiser
    typedef struct packed
    {
        logic load;
        logic step;
        logic big_endian;
        logic long_field;
    } hmp_len_ctrl_t;

endpackage

// ===== hw/rtl/hash_message_padder.sv =====
// Merkle-Damgard message padder for MD5/SHA style compression cores.
// Input channel (in_valid/in_ready): one request per message byte, with
// has_byte qualifying data_byte and is_last closing the message. A request
// with neither flag set is dropped. An empty message is a single request
// with is_last and no byte.
// Output channel (out_valid/out_ready): 64-bit words of the padded blocks,
// first byte in the low lane, flagged with block_end and message_end.
// Bytes are taken one per cycle unless stalled; a word appears in the output
// register in the cycle after its eighth byte is taken. After is_last the
// block stops taking requests and emits 0x80, zero fill (plus an extra block
// when the length no longer fits) and the 8- or 16-byte length field, one
// byte per cycle unless stalled, through the word shift register; no byte is
// emitted on the steps that leave the flush and fill states.
// The output register decouples the two sides: when out_ready is low only
// the byte that would complete a word is held back, so in_ready drops.
// Configuration writes (cfg_we/cfg_index/cfg_data) are registered and are to be
// made only while the block is idle; the block itself does not enforce this.
// Reset clears the configuration, counters and state; no words are pending.
module hash_message_padder
    import hmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_word,
    output logic        block_end,
    output logic        message_end
);

    hmp_state_t    state_reg;
    hmp_state_t    state_next;

    logic          block_sel_reg;
    logic          len_sel_reg;
    logic          len_be_reg;

    logic [6:0]    pos_reg;
    logic [6:0]    pos_next;
    logic [60:0]   count_reg;
    logic [60:0]   count_next;
    logic [63:0]   word_reg;
    logic [63:0]   word_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [63:0]   out_word_reg;
    logic          block_end_reg;
    logic          message_end_reg;

    logic [7:0]    block_bytes;
    logic [7:0]    room;
    logic [7:0]    pos_inc;
    logic          lane_last;
    logic          word_end;
    logic          stall;
    logic          extra;
    logic          accept;

    logic          push;
    logic [7:0]    push_value;
    logic          push_final;
    logic          count_clear;

    hmp_len_ctrl_t len_ctrl;
    logic [7:0]    len_byte;
    logic          len_last;

    // block geometry from configuration
    assign block_bytes = block_sel_reg ? BLOCK_BYTES_128 : BLOCK_BYTES_64;
    assign room        = block_bytes - (len_sel_reg ? LEN_BYTES_16 : LEN_BYTES_8);

    assign pos_inc   = {1'b0, pos_reg} + 8'd1;
    assign lane_last = (pos_reg[2:0] == 3'b111);
    assign word_end  = pos_inc >= block_bytes;
    assign stall     = lane_last && out_valid_reg && !out_ready;
    assign extra     = pos_inc > room;
    assign accept    = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_sel_reg <= 1'b0;
            len_sel_reg   <= 1'b0;
            len_be_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BLOCK_SIZE:  block_sel_reg <= cfg_data;
                CFG_LENGTH_SIZE: len_sel_reg   <= cfg_data;
                CFG_LENGTH_BE:   len_be_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_MSG:
            begin
                if (accept && is_last)
                begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                if (!stall)
                begin
                    state_next = extra ? ST_FLUSH : ST_FILL;
                end
            end
            ST_FLUSH:
            begin
                if (pos_reg == 7'd0)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if ({1'b0, pos_reg} >= room)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (!stall && len_last)
                begin
                    state_next = ST_MSG;
                end
            end
            default:
            begin
                state_next = ST_MSG;
            end
        endcase
    end

    // byte source and handshake per state
    always_comb
    begin
        in_ready            = 1'b0;
        push                = 1'b0;
        push_value          = PAD_ZERO;
        push_final          = 1'b0;
        count_clear         = 1'b0;
        len_ctrl.load       = 1'b0;
        len_ctrl.step       = 1'b0;
        len_ctrl.big_endian = len_be_reg;
        len_ctrl.long_field = len_sel_reg;
        case (state_reg)
            ST_MSG:
            begin
                in_ready   = !stall;
                push       = accept && has_byte;
                push_value = data_byte;
            end
            ST_MARK:
            begin
                push          = !stall;
                push_value    = PAD_MARK;
                len_ctrl.load = 1'b1;
            end
            ST_FLUSH:
            begin
                push = !stall && (pos_reg != 7'd0);
            end
            ST_FILL:
            begin
                push = !stall && ({1'b0, pos_reg} < room);
            end
            ST_LEN:
            begin
                push          = !stall;
                push_value    = len_byte;
                len_ctrl.step = !stall;
                push_final    = len_last;
                count_clear   = !stall && len_last;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    hmp_len_shift u_len_shift
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (len_ctrl),
        .byte_count (count_reg),
        .len_byte   (len_byte),
        .len_last   (len_last)
    );

    // byte shift register, block position and byte count
    always_comb
    begin
        word_next  = word_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        if (push)
        begin
            word_next = {push_value, word_reg[63:8]};
            if (lane_last && word_end)
            begin
                pos_next = 7'd0;
            end
            else
            begin
                pos_next = pos_inc[6:0];
            end
        end
        if (count_clear)
        begin
            count_next = 61'd0;
        end
        else if (accept && has_byte)
        begin
            count_next = count_reg + 61'd1;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (push && lane_last)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_MSG;
            pos_reg       <= 7'd0;
            count_reg     <= 61'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (push && lane_last)
        begin
            out_word_reg    <= word_next;
            block_end_reg   <= word_end;
            message_end_reg <= push_final;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_word    = out_word_reg;
    assign block_end   = block_end_reg;
    assign message_end = message_end_reg;

`ifndef SYNTHESIS
    // the padded message always closes on a block boundary
    a_msg_end_closes_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_end |-> block_end)
        else $error("message_end without block_end");

    // the length field sits in the tail of the block
    a_len_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LEN |-> {1'b0, pos_reg} >= room)
        else $error("length field outside block tail");

    // last length byte brings the block position back to the start and clears the byte count
    a_len_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LEN && push && len_last |=> pos_reg == 7'd0 && count_reg == 61'd0)
        else $error("block position or count not cleared after length field");

    // a completed word never overwrites one still waiting in the output register
    a_push_word_room: assert property (@(posedge clk) disable iff (!rst_n)
        push && lane_last |-> !out_valid_reg || out_ready)
        else $error("completed word overwrote a pending word");
`endif

endmodule

// ===== hw/rtl/hmp_len_shift.sv =====
module hmp_len_shift
    import hmp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  hmp_len_ctrl_t ctrl,
    input  logic [60:0]   byte_count,
    output logic [7:0]    len_byte,
    output logic          len_last
);

    logic [63:0] len_reg;
    logic [63:0] len_next;
    logic [3:0]  idx_reg;
    logic [3:0]  idx_next;
    logic        lead_zero;

    // big-endian 16-byte field opens with eight zero bytes
    assign lead_zero = ctrl.long_field && !idx_reg[3];

    // load the bit length, then shift one byte out per step
    always_comb
    begin
        len_next = len_reg;
        idx_next = idx_reg;
        if (ctrl.load)
        begin
            len_next = {byte_count, 3'b000};
            idx_next = 4'd0;
        end
        else if (ctrl.step)
        begin
            idx_next = idx_reg + 4'd1;
            if (ctrl.big_endian)
            begin
                if (!lead_zero)
                begin
                    len_next = {len_reg[55:0], 8'h00};
                end
            end
            else
            begin
                len_next = {8'h00, len_reg[63:8]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 4'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    // byte on the serial output
    always_comb
    begin
        if (ctrl.big_endian)
        begin
            len_byte = lead_zero ? 8'h00 : len_reg[63:56];
        end
        else
        begin
            len_byte = len_reg[7:0];
        end
    end

    assign len_last = (idx_reg == (ctrl.long_field ? 4'd15 : 4'd7));

endmodule
